>>> hdl/udk_pkg.sv
// types and constants shared by the distance keeping drive
`timescale 1ns / 1ps
package udk_pkg;

  localparam int DIST_W     = 13;
  localparam int ECHO_W     = 15;
  localparam int LEVEL_W    = 8;
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 4;
  localparam int READ_W     = 14;
  localparam int PROD_W     = 25;
  localparam int CFG_IDX_W  = 1;
  localparam int CMD_DEPTH  = 2;

  // echo to distance scaling, reading = (us * 557) >> 11
  localparam logic [PROD_W-1:0] ECHO_SCALE  = PROD_W'(557);
  localparam int                ECHO_SHIFT  = 11;
  localparam logic [READ_W-1:0] READ_MIN    = READ_W'(32);
  localparam logic [READ_W-1:0] READ_MAX    = READ_W'(6400);
  localparam logic [DIST_W-1:0] FAR_DIST    = DIST_W'(6400);

  // reverse curve
  localparam logic [DIST_W-1:0]  REV_NEAR   = DIST_W'(80);
  localparam logic [DIST_W-1:0]  REV_FAR    = DIST_W'(240);
  localparam logic [LEVEL_W-1:0] REV_MAX    = LEVEL_W'(180);
  localparam logic [LEVEL_W-1:0] REV_MIN    = LEVEL_W'(80);

  // advance curve
  localparam logic [DIST_W-1:0]  ADV_NEAR   = DIST_W'(320);
  localparam logic [DIST_W-1:0]  ADV_FAR    = DIST_W'(640);
  localparam logic [LEVEL_W-1:0] ADV_MIN    = LEVEL_W'(100);
  localparam logic [LEVEL_W-1:0] ADV_MAX    = LEVEL_W'(255);

  localparam logic [LEVEL_W-1:0] BOOST_LEVEL = LEVEL_W'(210);

  localparam logic [DIST_W-1:0] BAND_LOW_RST  = DIST_W'(288);
  localparam logic [DIST_W-1:0] BAND_HIGH_RST = DIST_W'(352);

  typedef enum logic [1:0] {
    OP_ECHO   = 2'd0,
    OP_DIRECT = 2'd1,
    OP_STOP   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MOT_STOP    = 2'd0,
    MOT_REVERSE = 2'd1,
    MOT_ADVANCE = 2'd2
  } motion_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_LOW  = 1'd0,
    REG_BAND_HIGH = 1'd1
  } reg_idx_t;

  typedef enum logic {
    CMD_DECIDE = 1'b0,
    CMD_HALT   = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DIST_W-1:0] distance;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] band_low;
    logic [DIST_W-1:0] band_high;
  } cfg_t;

  typedef struct packed {
    motion_t            motion;
    logic [LEVEL_W-1:0] level;
    logic               boost;
    logic [DIST_W-1:0]  distance;
    logic               last;
  } result_t;

endpackage

>>> hdl/udk_if.sv
// valid/ready channel interfaces for input items, results and configuration
`timescale 1ns / 1ps
interface udk_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [udk_pkg::ECHO_W-1:0]   echo_us;
  logic [udk_pkg::DIST_W-1:0]   distance_in;

  modport source (output valid, output op, output echo_us, output distance_in, input ready);
  modport sink (input valid, input op, input echo_us, input distance_in, output ready);
endinterface

interface udk_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   motion;
  logic [udk_pkg::LEVEL_W-1:0]  drive_level;
  logic                         boost;
  logic [udk_pkg::DIST_W-1:0]   distance_used;
  logic                         last;

  modport source (output valid, output motion, output drive_level, output boost,
                  output distance_used, output last, input ready);
  modport sink (input valid, input motion, input drive_level, input boost,
                input distance_used, input last, output ready);
endinterface

interface udk_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [udk_pkg::CFG_IDX_W-1:0]  index;
  logic [udk_pkg::DIST_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/udk_front.sv
// front end: accepts items, averages echo bursts and queues decide/halt commands
`timescale 1ns / 1ps
module udk_front #(
  parameter int SAMPLES_PER_BURST = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  udk_in_if.sink        in_ch,
  output udk_pkg::cmd_t push_cmd,
  output logic          push_valid,
  input  logic          push_ready
);
  import udk_pkg::*;

  localparam int IDX_W = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t       state_r, state_nxt;
  logic [DIST_W-1:0]  held_r, held_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]   div_r, div_nxt;
  logic [1:0]         step_r, step_nxt;
  cmd_t               cmd_r, cmd_nxt;

  logic               accept;
  logic [PROD_W-1:0]  echo_prod;
  logic [READ_W-1:0]  reading;
  logic               read_ok;
  logic [SUM_W-1:0]   sum_add;
  logic [CNT_W-1:0]   cnt_add;
  logic               burst_end;
  logic [SUM_W-1:0]   quo_step;
  logic [CNT_W:0]     rem_step;
  logic [DIST_W-1:0]  fallback;

  assign in_ch.ready = (state_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign echo_prod = PROD_W'(in_ch.echo_us) * ECHO_SCALE;
  assign reading   = echo_prod[ECHO_SHIFT +: READ_W];
  assign read_ok   = (reading > READ_MIN) && (reading < READ_MAX);
  assign sum_add   = read_ok ? sum_r + SUM_W'(reading) : sum_r;
  assign cnt_add   = read_ok ? cnt_r + CNT_W'(1) : cnt_r;
  assign burst_end = (int'(idx_r) + 1 == SAMPLES_PER_BURST);
  assign fallback  = (held_r != '0) ? held_r : FAR_DIST;

  // four restoring division steps a cycle
  always_comb begin
    logic [SUM_W-1:0] q;
    logic [CNT_W:0]   r;
    q = quo_r;
    r = rem_r;
    for (int i = 0; i < 4; i++) begin
      r = {r[CNT_W-1:0], q[SUM_W-1]};
      q = {q[SUM_W-2:0], 1'b0};
      if (r >= {1'b0, div_r}) begin
        r    = r - {1'b0, div_r};
        q[0] = 1'b1;
      end
    end
    quo_step = q;
    rem_step = r;
  end

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    cmd_nxt   = cmd_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          unique case (in_ch.op)
            OP_ECHO: begin
              if (burst_end) begin
                sum_nxt = '0;
                cnt_nxt = '0;
                idx_nxt = '0;
                if (cnt_add != '0) begin
                  quo_nxt   = sum_add;
                  rem_nxt   = '0;
                  div_nxt   = cnt_add;
                  step_nxt  = '0;
                  state_nxt = F_DIV;
                end else begin
                  held_nxt  = fallback;
                  cmd_nxt   = '{kind: CMD_DECIDE, distance: fallback};
                  state_nxt = F_PUSH;
                end
              end else begin
                sum_nxt = sum_add;
                cnt_nxt = cnt_add;
                idx_nxt = idx_r + IDX_W'(1);
              end
            end
            OP_DIRECT: begin
              cmd_nxt   = '{kind: CMD_DECIDE, distance: in_ch.distance_in};
              state_nxt = F_PUSH;
            end
            OP_STOP: begin
              cmd_nxt   = '{kind: CMD_HALT, distance: held_r};
              state_nxt = F_PUSH;
            end
            default: ;
          endcase
        end
      end
      F_DIV: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          held_nxt  = quo_step[DIST_W-1:0];
          cmd_nxt   = '{kind: CMD_DECIDE, distance: quo_step[DIST_W-1:0]};
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      held_r  <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
    cmd_r  <= cmd_nxt;
  end

  assign push_valid = (state_r == F_PUSH);
  assign push_cmd   = cmd_r;

endmodule

>>> hdl/udk_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps
module udk_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  udk_pkg::cmd_t push_cmd,
  input  logic          push_valid,
  output logic          push_ready,
  output udk_pkg::cmd_t head_cmd,
  output logic          head_valid,
  input  logic          pop
);
  import udk_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);

  cmd_t             slot_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != (PTR_W+1)'(CMD_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/udk_back.sv
// back end: band decision, drive level curves, kick-start and result register
`timescale 1ns / 1ps
module udk_back (
  input  logic          clk,
  input  logic          rst_n,
  input  udk_pkg::cfg_t cfg,
  input  udk_pkg::cmd_t head_cmd,
  input  logic          head_valid,
  output logic          pop,
  udk_out_if.source     out_ch
);
  import udk_pkg::*;

  logic               moving_r, moving_nxt;
  result_t            out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            pend_r, pend_nxt;
  logic               pend_valid_r, pend_valid_nxt;

  logic               slot_free;
  logic [DIST_W-1:0]  d;
  logic               in_band, below;
  logic [7:0]         rev_gap;
  logic [10:0]        rev_prod;
  logic [8:0]         adv_gap;
  logic [13:0]        adv_prod;
  logic [LEVEL_W-1:0] rev_level, adv_level;
  result_t            real_res;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop       = head_valid && slot_free && !pend_valid_r;

  assign d       = head_cmd.distance;
  assign in_band = (d >= cfg.band_low) && (d <= cfg.band_high);
  assign below   = (d < cfg.band_low);

  // 10/16 slope between 5 and 15 cm
  assign rev_gap  = 8'(REV_FAR - d);
  assign rev_prod = 11'(rev_gap) * 11'd5;
  always_comb begin
    if (d <= REV_NEAR) begin
      rev_level = REV_MAX;
    end else if (d >= REV_FAR) begin
      rev_level = REV_MIN;
    end else begin
      rev_level = REV_MIN + LEVEL_W'(rev_prod >> 3);
    end
  end

  // 155/320 = 31/64 slope between 20 and 40 cm
  assign adv_gap  = 9'(d - ADV_NEAR);
  assign adv_prod = 14'(adv_gap) * 14'd31;
  always_comb begin
    if (d >= ADV_FAR) begin
      adv_level = ADV_MAX;
    end else if (d <= ADV_NEAR) begin
      adv_level = ADV_MIN;
    end else begin
      adv_level = ADV_MIN + LEVEL_W'(adv_prod >> 6);
    end
  end

  always_comb begin
    real_res = '{motion: below ? MOT_REVERSE : MOT_ADVANCE,
                 level: below ? rev_level : adv_level,
                 boost: 1'b0, distance: d, last: 1'b1};
  end

  always_comb begin
    moving_nxt     = moving_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (slot_free) begin
      if (pend_valid_r) begin
        out_nxt        = pend_r;
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = 1'b0;
      end else if (head_valid) begin
        out_valid_nxt = 1'b1;
        if (head_cmd.kind == CMD_HALT || in_band) begin
          out_nxt    = '{motion: MOT_STOP, level: '0, boost: 1'b0, distance: d, last: 1'b1};
          moving_nxt = 1'b0;
        end else begin
          moving_nxt = 1'b1;
          if (!moving_r) begin
            out_nxt        = '{motion: real_res.motion, level: BOOST_LEVEL,
                               boost: 1'b1, distance: d, last: 1'b0};
            pend_nxt       = real_res;
            pend_valid_nxt = 1'b1;
          end else begin
            out_nxt = real_res;
          end
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      moving_r     <= moving_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.motion        = out_r.motion;
  assign out_ch.drive_level   = out_r.level;
  assign out_ch.boost         = out_r.boost;
  assign out_ch.distance_used = out_r.distance;
  assign out_ch.last          = out_r.last;

`ifndef SYNTH
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("queued second result without a first one in the output register");

  a_boost_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.boost) |-> (out_r.level == BOOST_LEVEL && !out_r.last
                                      && out_r.motion != MOT_STOP))
    else $error("kick-start result malformed");

  a_boost_then_real: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.boost && out_ch.ready) |=> (out_valid_r && !out_r.boost && out_r.last))
    else $error("kick-start not followed by its drive result");

  a_stop_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.motion == MOT_STOP) |-> (out_r.level == '0 && !out_r.boost))
    else $error("stopped result carries a drive level");
`endif

endmodule

>>> hdl/ultrasonic_distance_keeping_drive_core.sv
// top level of the ultrasonic distance keeping drive
`timescale 1ns / 1ps
// Ultrasonic distance keeping drive. Input transfers carry an op: an echo
// sample (pulse length in us), a direct distance, or a stop request; all
// distances are sixteenths of a cm. Echo samples are grouped in bursts of
// SAMPLES_PER_BURST, and only the sample that closes a burst yields results.
// Each decision gives one result transfer, or two when the drive starts from
// standstill (a kick-start at level 210 marked boost, then the real level
// with last set). An echo sample that does not close a burst, or an unused
// op, is only accepted; other items pass accept and the queue push, with the
// 4-bit-a-cycle averaging divider between them for a burst end with valid
// readings. A two-entry command queue decouples the front end from the
// result side, which emits one result per cycle while the receiver is
// ready; the queue keeps taking commands while a result waits in the
// output register. The user must write the band registers through the cfg
// channel (index 0 low edge, index 1 high edge) only while no item is in
// flight; the block does not enforce this. cfg writes are always taken.
module ultrasonic_distance_keeping_drive_core #(
  parameter int SAMPLES_PER_BURST = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  udk_in_if.sink    in_ch,
  udk_out_if.source out_ch,
  udk_cfg_if.sink   cfg_ch
);
  import udk_pkg::*;

  // band registers
  logic [DIST_W-1:0] band_low_r, band_low_nxt;
  logic [DIST_W-1:0] band_high_r, band_high_nxt;
  cfg_t              cfg;

  // front to queue, queue to back
  cmd_t              push_cmd, head_cmd;
  logic              push_valid, push_ready;
  logic              head_valid, pop;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    band_low_nxt  = band_low_r;
    band_high_nxt = band_high_r;
    if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_BAND_LOW:  band_low_nxt  = cfg_ch.data;
        REG_BAND_HIGH: band_high_nxt = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r  <= BAND_LOW_RST;
      band_high_r <= BAND_HIGH_RST;
    end else begin
      band_low_r  <= band_low_nxt;
      band_high_r <= band_high_nxt;
    end
  end

  assign cfg = '{band_low: band_low_r, band_high: band_high_r};

  // burst averaging and command building
  udk_front #(
    .SAMPLES_PER_BURST (SAMPLES_PER_BURST)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // lets the front end run ahead while results stall
  udk_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // decision, level curves, kick-start and output register
  udk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

>>> tb/tb_ultrasonic_distance_keeping_drive_core.sv
// self-checking testbench for the ultrasonic distance keeping drive core
`timescale 1ns / 1ps
module tb_ultrasonic_distance_keeping_drive_core;
  import udk_pkg::*;

  localparam int         BURST       = 5;
  localparam logic [1:0] OP_UNUSED   = 2'd3;  // op code the block must ignore
  localparam int         IDLE_PCT    = 17;
  localparam int         SETTLE      = 12;    // covers a burst end and the queue
  localparam int         HOLD_CYCLES = 300;
  localparam int         QUIET_LIMIT = 3000;
  localparam int         PRINT_CAP   = 30;
  localparam int         PHASES      = 10;
  localparam int         PHASE_ITEMS = 90;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  udk_in_if  in_ch();
  udk_out_if out_ch();
  udk_cfg_if cfg_ch();

  ultrasonic_distance_keeping_drive_core #(
    .SAMPLES_PER_BURST(BURST)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // own copy of the band registers and of the drive state
  logic [DIST_W-1:0] band_lo;
  logic [DIST_W-1:0] band_hi;
  logic [DIST_W-1:0] held_dist;
  logic [SUM_W-1:0]  burst_sum;
  logic [CNT_W-1:0]  valid_cnt;
  int                burst_idx;
  int                prev_drive;   // +level reversing, -level advancing, 0 at standstill

  // drive results still owed by the block, oldest first
  result_t drive_forecast[$];

  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int band_settings   = 1;
  int quiet_cycles    = 0;

  // idling controls; the receiver hold-off is handed over by a request count
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // ---------------------------------------------------------------- prediction

  function automatic void expect_result(input motion_t m, input logic [LEVEL_W-1:0] lvl,
                                        input logic b, input logic [DIST_W-1:0] d,
                                        input logic l);
    result_t r;
    r.motion   = m;
    r.level    = lvl;
    r.boost    = b;
    r.distance = d;
    r.last     = l;
    drive_forecast.push_back(r);
  endfunction

  // stop inside the band, else reverse or advance along the level curves
  function automatic void plan_decision(input logic [DIST_W-1:0] d);
    motion_t m;
    int      lvl;
    int      drive;
    if (d >= band_lo && d <= band_hi) begin
      prev_drive = 0;
      expect_result(MOT_STOP, '0, 1'b0, d, 1'b1);
      return;
    end
    if (d < band_lo) begin
      m = MOT_REVERSE;
      if (d <= REV_NEAR) lvl = int'(REV_MAX);
      else if (d >= REV_FAR) lvl = int'(REV_MIN);
      else lvl = int'(REV_MIN) + (int'(REV_FAR) - int'(d)) * 10 / 16;
      drive = lvl;
    end else begin
      m = MOT_ADVANCE;
      if (d >= ADV_FAR) lvl = int'(ADV_MAX);
      else if (d <= ADV_NEAR) lvl = int'(ADV_MIN);
      else lvl = int'(ADV_MIN) + (int'(d) - int'(ADV_NEAR)) * 155 / 320;
      drive = -lvl;
    end
    // kick-start only when leaving standstill, not on a change of direction
    if (prev_drive == 0) expect_result(m, BOOST_LEVEL, 1'b1, d, 1'b0);
    expect_result(m, LEVEL_W'(lvl), 1'b0, d, 1'b1);
    prev_drive = drive;
  endfunction

  function automatic void forecast_item(input logic [1:0] op, input logic [ECHO_W-1:0] echo,
                                        input logic [DIST_W-1:0] dist_in);
    int                reading;
    logic [DIST_W-1:0] d;
    case (op)
      OP_ECHO: begin
        reading = (int'(echo) * int'(ECHO_SCALE)) >> ECHO_SHIFT;
        if (reading > int'(READ_MIN) && reading < int'(READ_MAX)) begin
          burst_sum = burst_sum + SUM_W'(reading);
          valid_cnt = valid_cnt + 1'b1;
        end
        burst_idx++;
        if (burst_idx == BURST) begin
          if (valid_cnt != 0) d = DIST_W'(burst_sum / valid_cnt);
          else if (held_dist != 0) d = held_dist;
          else d = FAR_DIST;
          held_dist = d;
          burst_sum = '0;
          valid_cnt = '0;
          burst_idx = 0;
          plan_decision(d);
        end
      end
      OP_DIRECT: plan_decision(dist_in);
      OP_STOP: begin
        prev_drive = 0;
        expect_result(MOT_STOP, '0, 1'b0, held_dist, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [ECHO_W-1:0] rand_echo_bits();
    return ECHO_W'($urandom_range(32767));
  endfunction

  function automatic logic [DIST_W-1:0] rand_dist_bits();
    return DIST_W'($urandom_range(8191));
  endfunction

  // echo lengths that give readings around the band, across the valid range and outside it
  function automatic logic [ECHO_W-1:0] pick_echo();
    int p;
    p = $urandom_range(99);
    if (p < 45) return ECHO_W'($urandom_range(2000, 400));
    if (p < 65) return ECHO_W'($urandom_range(23531, 122));
    if (p < 75) return '0;
    if (p < 85) return ECHO_W'($urandom_range(121, 1));
    if (p < 92) return ECHO_W'($urandom_range(30000, 23532));
    return ECHO_W'($urandom_range(32767, 30001));
  endfunction

  // echo lengths whose readings are all rejected
  function automatic logic [ECHO_W-1:0] blind_echo();
    if ($urandom_range(1) == 0) return ECHO_W'($urandom_range(121));
    return ECHO_W'($urandom_range(32767, 23532));
  endfunction

  // ---------------------------------------------------------------- channel tasks

  // one input transfer; valid stays high if the next call comes at once
  task automatic send_item(input logic [1:0] op, input logic [ECHO_W-1:0] echo,
                           input logic [DIST_W-1:0] dist_in);
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.echo_us     <= echo;
    in_ch.distance_in <= dist_in;
    do @(posedge clk); while (!in_ch.ready);
    forecast_item(op, echo, dist_in);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_direct(input int d);
    send_item(OP_DIRECT, rand_echo_bits(), DIST_W'(d));
  endtask

  task automatic send_echo(input int us);
    send_item(OP_ECHO, ECHO_W'(us), rand_dist_bits());
  endtask

  task automatic send_stop();
    send_item(OP_STOP, rand_echo_bits(), rand_dist_bits());
  endtask

  task automatic send_ignored();
    send_item(OP_UNUSED, rand_echo_bits(), rand_dist_bits());
  endtask

  // wait until every owed result is in, then let any result-free item finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (drive_forecast.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DIST_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_BAND_LOW) band_lo = val;
    else band_hi = val;
    reg_writes++;
  endtask

  task automatic set_band(input int lo, input int hi);
    settle();
    write_reg(REG_BAND_LOW, DIST_W'(lo));
    write_reg(REG_BAND_HIGH, DIST_W'(hi));
    band_settings++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: mismatch on %s, got %0d expected %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------- receiver and checks

  // random stalls, plus a long hold-off on request so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= !(sink_idle_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  // every result transfer is matched against the oldest owed result
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_forecast.size() == 0) begin
        report_mismatch("unexpected result, distance", out_ch.distance_used, 0);
      end else begin
        want = drive_forecast.pop_front();
        results_checked++;
        if (out_ch.motion !== want.motion)
          report_mismatch("motion", out_ch.motion, want.motion);
        if (out_ch.drive_level !== want.level)
          report_mismatch("drive_level", out_ch.drive_level, want.level);
        if (out_ch.boost !== want.boost)
          report_mismatch("boost", out_ch.boost, want.boost);
        if (out_ch.distance_used !== want.distance)
          report_mismatch("distance_used", out_ch.distance_used, want.distance);
        if (out_ch.last !== want.last)
          report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  // ends the run if no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results owed", quiet_cycles,
               drive_forecast.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // band edges at the reset setting, a turn without a stop, a stop request
  task automatic test_band_edges();
    send_direct(287);
    send_direct(288);
    send_direct(352);
    send_direct(353);
    send_direct(100);
    send_stop();
  endtask

  // reverse curve at both clamps and just inside them, advance top clamp, field top
  task automatic test_level_curves();
    send_direct(0);
    send_direct(80);
    send_direct(81);
    send_direct(239);
    send_direct(240);
    send_direct(639);
    send_direct(640);
    send_direct(6400);
    send_direct(8191);
  endtask

  // empty burst with nothing held, then readings at both validity limits
  task automatic test_echo_bursts();
    send_echo(0);
    send_echo(32767);
    send_echo(0);
    send_echo(0);
    send_echo(0);
    send_echo(121);
    send_echo(122);
    send_ignored();
    send_echo(23531);
    send_echo(23533);
    send_echo(0);
    send_stop();
  endtask

  // receiver holds off while the sender keeps offering transfers
  task automatic test_backpressure();
    settle();
    src_idle_en = 1'b0;
    hold_reqs  <= hold_reqs + 1;
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_direct($urandom_range(287));
        1: send_direct($urandom_range(6400, 353));
        2: send_direct($urandom_range(352, 288));
        default: send_direct($urandom_range(8191));
      endcase
    end
    settle();
    src_idle_en = 1'b1;
  endtask

  // complete the open burst, now and then with nothing but rejected readings
  task automatic send_burst();
    int n;
    bit blind;
    n     = BURST - burst_idx;
    blind = ($urandom_range(9) == 0);
    repeat (n) send_item(OP_ECHO, blind ? blind_echo() : pick_echo(), rand_dist_bits());
  endtask

  task automatic random_step();
    int p;
    int q;
    int c;
    p = $urandom_range(99);
    if (p < 50) begin
      send_burst();
    end else if (p < 75) begin
      q = $urandom_range(99);
      if (q < 40) c = $urandom_range(700);
      else if (q < 75) c = $urandom_range(6400);
      else if (q < 90) begin
        c = (q % 2 == 0) ? int'(band_lo) : int'(band_hi);
        c = c + int'($urandom_range(4)) - 2;
        if (c < 0) c = 0;
        if (c > 8191) c = 8191;
      end else c = $urandom_range(8191, 6401);
      send_direct(c);
    end else if (p < 85) begin
      send_stop();
    end else if (p < 92) begin
      send_ignored();
    end else begin
      // lone sample, which may leave a burst open
      send_item(OP_ECHO, pick_echo(), rand_dist_bits());
    end
  endtask

  // phases over the band extremes, an inverted band, the field top and random bands
  task automatic test_random_phases();
    int lows[PHASES];
    int highs[PHASES];
    int start;
    lows  = '{0, 0, 6400, 6400, 7000, 288, 0, 0, 0, 0};
    highs = '{6400, 0, 6400, 0, 8191, 352, 0, 0, 0, 0};
    for (int k = 6; k < PHASES; k++) begin
      lows[k]  = $urandom_range(700);
      highs[k] = lows[k] + $urandom_range(200);
    end
    for (int k = 0; k < PHASES; k++) begin
      set_band(lows[k], highs[k]);
      // one phase runs flat out on both sides
      src_idle_en   = (k != 5);
      sink_idle_en <= (k != 5);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) random_step();
    end
    settle();
    src_idle_en   = 1'b1;
    sink_idle_en <= 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_ECHO;
    in_ch.echo_us     = '0;
    in_ch.distance_in = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_BAND_LOW;
    cfg_ch.data       = '0;
    out_ch.ready      = 1'b0;

    band_lo    = BAND_LOW_RST;
    band_hi    = BAND_HIGH_RST;
    held_dist  = '0;
    burst_sum  = '0;
    valid_cnt  = '0;
    burst_idx  = 0;
    prev_drive = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_band_edges();
    test_level_curves();
    test_echo_bursts();
    test_backpressure();
    test_random_phases();
    settle();

    $display("covered %0d input transfers over %0d band settings with %0d register writes",
             items_sent, band_settings, reg_writes);
    $display("checked %0d result transfers, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/udk_pkg.sv
hdl/udk_if.sv
hdl/udk_front.sv
hdl/udk_cmd_fifo.sv
hdl/udk_back.sv
hdl/ultrasonic_distance_keeping_drive_core.sv
tb/tb_ultrasonic_distance_keeping_drive_core.sv
